// ----- hdl/soca_pkg.sv -----
`default_nettype none
package soca_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_EMIT  = 16;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int COORD_W = 11;
    localparam int POLY_W  = 8;
    localparam int COUNT_W = 20;
    localparam int SUM_W   = 32;
    localparam int LEN_W   = 11;
    localparam int PROD_W  = 22;
    localparam int DX_W    = 23;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_SPAN   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic              load_in;
        logic              clear;
        logic              mul;
        logic              sum;
        logic              upd_a;
        logic              upd_b;
        logic              fin_load;
        logic              out_load;
        logic              out_last;
        logic [SLOT_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic span_ok;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/soca_div.sv -----
`default_nettype none
module soca_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [soca_pkg::SUM_W-1:0]   num,
    input  wire logic [soca_pkg::COUNT_W-1:0] den,
    output logic                              busy,
    output logic [soca_pkg::COORD_W-1:0]      quot
);
    import soca_pkg::*;

    localparam int CW = $clog2(COORD_W + 1);
    localparam int DW = COUNT_W + COORD_W - 1;

    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [DW-1:0]      dvs_reg, dvs_next;
    logic [COORD_W-1:0] quot_reg, quot_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               over;
    logic               ge;

    // quotient would not fit in COORD_W bits: clamp to all ones
    assign over = num[SUM_W-1:COORD_W] >= (SUM_W-COORD_W)'(den);
    assign ge   = rem_reg >= SUM_W'(dvs_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next = num;
            dvs_next = {den, {(COORD_W-1){1'b0}}};
            if (over)
            begin
                quot_next = '1;
                cnt_next  = '0;
            end
            else
            begin
                quot_next = '0;
                cnt_next  = CW'(COORD_W);
            end
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
                rem_next = rem_reg - SUM_W'(dvs_reg);
            quot_next = {quot_reg[COORD_W-2:0], ge};
            dvs_next  = dvs_reg >> 1;
            cnt_next  = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;

endmodule
`default_nettype wire

// ----- hdl/soca_dp.sv -----
`default_nettype none
module soca_dp #(
    parameter int SLOTS = soca_pkg::SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire soca_pkg::cmd_t               cmd,
    output soca_pkg::sts_t                    sts,
    input  wire logic [soca_pkg::SLOT_W-1:0]  slot_a,
    input  wire logic [soca_pkg::SLOT_W-1:0]  slot_b,
    input  wire logic [soca_pkg::COORD_W-1:0] row,
    input  wire logic [soca_pkg::COORD_W-1:0] x_start,
    input  wire logic [soca_pkg::COORD_W-1:0] x_end,
    input  wire logic [soca_pkg::POLY_W-1:0]  poly_a,
    input  wire logic [soca_pkg::POLY_W-1:0]  poly_b,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [soca_pkg::SLOT_W-1:0]       slot,
    output logic                              hit,
    output logic [soca_pkg::COORD_W-1:0]      centre_x,
    output logic [soca_pkg::COORD_W-1:0]      centre_y,
    output logic [soca_pkg::COUNT_W-1:0]      pixel_count,
    output logic [soca_pkg::POLY_W-1:0]       partner,
    output logic                              last
);
    import soca_pkg::*;

    // slot indices are SLOT_W wide, so no more than MAX_EMIT entries are reachable
    localparam int DEPTH = (SLOTS < MAX_EMIT) ? SLOTS : MAX_EMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COUNT_W-1:0] cnt_store_reg [DEPTH];
    logic [SUM_W-1:0]   xsum_store_reg [DEPTH];
    logic [SUM_W-1:0]   ysum_store_reg [DEPTH];
    logic [POLY_W-1:0]  par_store_reg [DEPTH];

    // span word
    logic [SLOT_W-1:0]  sa_reg, sb_reg;
    logic [POLY_W-1:0]  pa_reg, pb_reg;
    logic [COORD_W-1:0] row_reg, xs_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               span_ok_reg;
    logic [PROD_W-1:0]  px_reg, tri_reg, py_reg;
    logic [DX_W-1:0]    dx_reg;
    logic [PROD_W-1:0]  dy_reg;

    logic [LEN_W:0]     len_p1;
    logic [LEN_W*2:0]   tri_full;

    logic [SLOT_W-1:0]  upd_sel;
    logic [POLY_W-1:0]  upd_par;
    logic               upd_ok;
    logic [AW-1:0]      rd_idx;
    logic [COUNT_W:0]   cnt_sum;
    logic [SUM_W:0]     xs_sum, ys_sum;
    logic [COUNT_W-1:0] cnt_new;
    logic [SUM_W-1:0]   xsum_new, ysum_new;

    // finish
    logic [COUNT_W-1:0] fin_cnt_reg;
    logic [POLY_W-1:0]  fin_par_reg;
    logic               div_busy_x, div_busy_y;
    logic [COORD_W-1:0] quot_x, quot_y;
    logic               fin_hit;

    // output register
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               hit_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic [COUNT_W-1:0] pc_reg;
    logic [POLY_W-1:0]  par_reg;
    logic               last_reg;

    assign len_p1   = {1'b0, len_reg} + (LEN_W+1)'(1);
    assign tri_full = (LEN_W*2+1)'(len_reg) * (LEN_W*2+1)'(len_p1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sa_reg  <= slot_a;
            sb_reg  <= slot_b;
            pa_reg  <= poly_a;
            pb_reg  <= poly_b;
            row_reg <= row;
            xs_reg  <= x_start;
            len_reg <= x_end - x_start;
        end
        if (cmd.mul)
        begin
            px_reg  <= PROD_W'(xs_reg) * PROD_W'(len_reg);
            tri_reg <= tri_full[PROD_W:1];
            py_reg  <= PROD_W'(len_reg) * PROD_W'(row_reg);
        end
        if (cmd.sum)
        begin
            dx_reg <= DX_W'(px_reg) + DX_W'(tri_reg);
            dy_reg <= py_reg;
        end
        if (cmd.fin_load)
        begin
            fin_cnt_reg <= cnt_store_reg[rd_idx];
            fin_par_reg <= par_store_reg[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_ok_reg <= 1'b0;
        else if (cmd.load_in)
            span_ok_reg <= x_end > x_start;
    end

    // slot a takes poly_b as partner, slot b takes poly_a
    assign upd_sel = cmd.upd_a ? sa_reg : sb_reg;
    assign upd_par = cmd.upd_a ? pb_reg : pa_reg;
    assign upd_ok  = 32'(upd_sel) < SLOTS;
    assign rd_idx  = cmd.fin_load ? cmd.idx[AW-1:0] : upd_sel[AW-1:0];

    assign cnt_sum  = {1'b0, cnt_store_reg[rd_idx]} + (COUNT_W+1)'(len_reg);
    assign xs_sum   = {1'b0, xsum_store_reg[rd_idx]} + (SUM_W+1)'(dx_reg);
    assign ys_sum   = {1'b0, ysum_store_reg[rd_idx]} + (SUM_W+1)'(dy_reg);
    assign cnt_new  = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
    assign xsum_new = xs_sum[SUM_W] ? '1 : xs_sum[SUM_W-1:0];
    assign ysum_new = ys_sum[SUM_W] ? '1 : ys_sum[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cnt_store_reg[i]  <= '0;
                xsum_store_reg[i] <= '0;
                ysum_store_reg[i] <= '0;
                par_store_reg[i]  <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cnt_store_reg[i]  <= '0;
                xsum_store_reg[i] <= '0;
                ysum_store_reg[i] <= '0;
                par_store_reg[i]  <= '0;
            end
        end
        else if ((cmd.upd_a || cmd.upd_b) && upd_ok)
        begin
            cnt_store_reg[rd_idx]  <= cnt_new;
            xsum_store_reg[rd_idx] <= xsum_new;
            ysum_store_reg[rd_idx] <= ysum_new;
            par_store_reg[rd_idx]  <= upd_par;
        end
    end

    soca_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.fin_load),
        .num   (xsum_store_reg[rd_idx]),
        .den   (cnt_store_reg[rd_idx]),
        .busy  (div_busy_x),
        .quot  (quot_x)
    );

    soca_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.fin_load),
        .num   (ysum_store_reg[rd_idx]),
        .den   (cnt_store_reg[rd_idx]),
        .busy  (div_busy_y),
        .quot  (quot_y)
    );

    assign fin_hit = fin_cnt_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            slot_reg <= cmd.idx;
            hit_reg  <= fin_hit;
            cx_reg   <= fin_hit ? quot_x : '0;
            cy_reg   <= fin_hit ? quot_y : '0;
            pc_reg   <= fin_cnt_reg;
            par_reg  <= fin_par_reg;
            last_reg <= cmd.out_last;
        end
    end

    assign sts.span_ok  = span_ok_reg;
    assign sts.div_busy = div_busy_x || div_busy_y;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign hit         = hit_reg;
    assign centre_x    = cx_reg;
    assign centre_y    = cy_reg;
    assign pixel_count = pc_reg;
    assign partner     = par_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

// ----- hdl/soca_ctrl.sv -----
`default_nettype none
module soca_ctrl #(
    parameter int SLOTS = soca_pkg::SLOTS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [soca_pkg::OP_W-1:0] op,
    output soca_pkg::cmd_t                 cmd,
    input  wire soca_pkg::sts_t            sts
);
    import soca_pkg::*;

    localparam int DEPTH = (SLOTS < MAX_EMIT) ? SLOTS : MAX_EMIT;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_UPA   = 3'd3;
    localparam logic [2:0] S_UPB   = 3'd4;
    localparam logic [2:0] S_FLOAD = 3'd5;
    localparam logic [2:0] S_FDIV  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              at_last;

    assign at_last = idx_reg == SLOT_W'(DEPTH - 1);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (op)
                        OP_START:
                            cmd.clear = 1'b1;
                        OP_SPAN:
                        begin
                            cmd.load_in = 1'b1;
                            state_next  = S_MUL;
                        end
                        OP_FINISH:
                        begin
                            idx_next   = '0;
                            state_next = S_FLOAD;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sts.span_ok ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_UPA;
            end
            S_UPA:
            begin
                cmd.upd_a  = 1'b1;
                state_next = S_UPB;
            end
            S_UPB:
            begin
                cmd.upd_b  = 1'b1;
                state_next = S_IDLE;
            end
            S_FLOAD:
            begin
                cmd.fin_load = 1'b1;
                state_next   = S_FDIV;
            end
            S_FDIV:
            begin
                if (!sts.div_busy && sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = at_last;
                    if (at_last)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + SLOT_W'(1);
                        state_next = S_FLOAD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/span_overlap_centroid_accumulator.sv -----
// Span overlap centroid accumulator.
// Input channel (in_valid/in_ready) takes one word per op: start clears all
// slots, span adds a scanline span to slot_a and slot_b, finish emits one
// result word per slot on the output channel (out_valid/out_ready), slot 0
// upward, the final one with last set. Op 3 is dropped.
// in_ready is high only while the controller is idle.
// Start: done in the accepting step. Span: accept, multiply, sum, update slot a,
// update slot b; an empty or reversed span ends after the multiply.
// Finish: per slot one store read plus an 11-step restoring
// divide (x and y in parallel); an empty slot or one whose mean
// clamps skips the divide.
// The first result is loaded into the output register once slot 0 has
// been read and divided.
// Results go through a single output register: a stalled receiver holds the
// controller before it loads the next slot, and after the last slot the
// input side reopens while that result still waits.
// Reset clears every slot, the controller and the output valid at once.
`default_nettype none
module span_overlap_centroid_accumulator #(
    parameter int SLOTS = soca_pkg::SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [soca_pkg::OP_W-1:0]    op,
    input  wire logic [soca_pkg::SLOT_W-1:0]  slot_a,
    input  wire logic [soca_pkg::SLOT_W-1:0]  slot_b,
    input  wire logic [soca_pkg::COORD_W-1:0] row,
    input  wire logic [soca_pkg::COORD_W-1:0] x_start,
    input  wire logic [soca_pkg::COORD_W-1:0] x_end,
    input  wire logic [soca_pkg::POLY_W-1:0]  poly_a,
    input  wire logic [soca_pkg::POLY_W-1:0]  poly_b,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [soca_pkg::SLOT_W-1:0]       slot,
    output logic                              hit,
    output logic [soca_pkg::COORD_W-1:0]      centre_x,
    output logic [soca_pkg::COORD_W-1:0]      centre_y,
    output logic [soca_pkg::COUNT_W-1:0]      pixel_count,
    output logic [soca_pkg::POLY_W-1:0]       partner,
    output logic                              last
);
    import soca_pkg::*;

    cmd_t cmd;
    sts_t sts;

    soca_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .cmd      (cmd),
        .sts      (sts)
    );

    soca_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .slot_a      (slot_a),
        .slot_b      (slot_b),
        .row         (row),
        .x_start     (x_start),
        .x_end       (x_end),
        .poly_a      (poly_a),
        .poly_b      (poly_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot        (slot),
        .hit         (hit),
        .centre_x    (centre_x),
        .centre_y    (centre_y),
        .pixel_count (pixel_count),
        .partner     (partner),
        .last        (last)
    );

endmodule
`default_nettype wire
